FILE: rtl/lwfs_pkg.sv
// Package for the LCD window fill sequencer: codes, step numbers and shared types.
// Has no dependencies; every other file of the block refers to it by scoped names.
package lwfs_pkg;

    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

    localparam logic [12:0] SCREEN_MAX          = 13'd4096;
    localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd320;
    localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd240;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [3:0] STEP_COL_CMD    = 4'd0;
    localparam logic [3:0] STEP_COL_BEG_HI = 4'd1;
    localparam logic [3:0] STEP_COL_BEG_LO = 4'd2;
    localparam logic [3:0] STEP_COL_END_HI = 4'd3;
    localparam logic [3:0] STEP_COL_END_LO = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD    = 4'd5;
    localparam logic [3:0] STEP_ROW_BEG_HI = 4'd6;
    localparam logic [3:0] STEP_ROW_BEG_LO = 4'd7;
    localparam logic [3:0] STEP_ROW_END_HI = 4'd8;
    localparam logic [3:0] STEP_ROW_END_LO = 4'd9;
    localparam logic [3:0] STEP_WRITE_CMD  = 4'd10;
    localparam logic [3:0] STEP_PIXEL      = 4'd11;

    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2
    } comp_t;

    typedef struct packed {
        logic        accept;
        logic [11:0] col_end;
        logic [11:0] row_end;
        logic [12:0] span_cols;
        logic [12:0] span_rows;
    } clip_t;

endpackage

FILE: rtl/lwfs_clip.sv
// Window clipping for the LCD window fill sequencer: drop test and far-corner clip.
// Depends on lwfs_pkg for the clip_t result type.
module lwfs_clip
(
    input  logic [11:0]    rect_x,
    input  logic [11:0]    rect_y,
    input  logic [12:0]    rect_width,
    input  logic [12:0]    rect_height,
    input  logic [12:0]    screen_width,
    input  logic [12:0]    screen_height,
    output lwfs_pkg::clip_t clip
);

    logic [13:0] far_x;
    logic [13:0] far_y;
    logic [11:0] col_end;
    logic [11:0] row_end;

    assign far_x = 14'(rect_x) + 14'(rect_width) - 14'd1;
    assign far_y = 14'(rect_y) + 14'(rect_height) - 14'd1;

    always_comb
    begin
        if (far_x >= 14'(screen_width))
        begin
            col_end = 12'(screen_width - 13'd1);
        end
        else
        begin
            col_end = far_x[11:0];
        end
        if (far_y >= 14'(screen_height))
        begin
            row_end = 12'(screen_height - 13'd1);
        end
        else
        begin
            row_end = far_y[11:0];
        end
    end

    assign clip.accept = (rect_width != 13'd0) && (rect_height != 13'd0)
                         && ({1'b0, rect_x} < screen_width)
                         && ({1'b0, rect_y} < screen_height);
    assign clip.col_end   = col_end;
    assign clip.row_end   = row_end;
    assign clip.span_cols = 13'(col_end - rect_x) + 13'd1;
    assign clip.span_rows = 13'(row_end - rect_y) + 13'd1;

endmodule

FILE: rtl/lcd_window_fill_sequencer.sv
// Top level of the LCD window fill sequencer: request register, byte sequencer, result register.
// Depends on lwfs_pkg and instantiates lwfs_clip.
//
//   channel   signals                                              role
//   req       req_valid, req_stall, cmd, rect_*, color_*           input transactions
//   rsp       rsp_valid, rsp_stall, tx_byte, is_data,              display bytes
//             transfer_end, fill_done
//   cfg       cfg_wr_en, cfg_index, cfg_data                       screen size writes
//
// A request transaction is registered on acceptance and handled once the result register can take
// it, so the block takes one transaction per cycle while rsp does not stall; an advance puts its
// byte on rsp through the request register and then the result register.
// Reset clears the valid flags, the busy state and the screen size to 320 by 240.
// A stall on rsp holds the result register and, through it, the request register.
module lcd_window_fill_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        cmd,
    input  logic [11:0] rect_x,
    input  logic [11:0] rect_y,
    input  logic [12:0] rect_width,
    input  logic [12:0] rect_height,
    input  logic [7:0]  color_red,
    input  logic [7:0]  color_green,
    input  logic [7:0]  color_blue,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  tx_byte,
    output logic        is_data,
    output logic        transfer_end,
    output logic        fill_done,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [12:0] cfg_value;

    logic        req_valid_reg;
    logic        cmd_reg;
    logic [11:0] rect_x_reg;
    logic [11:0] rect_y_reg;
    logic [12:0] rect_width_reg;
    logic [12:0] rect_height_reg;
    logic [7:0]  color_red_reg;
    logic [7:0]  color_green_reg;
    logic [7:0]  color_blue_reg;

    logic            busy_reg,       busy_next;
    logic [3:0]      step_reg,       step_next;
    logic [11:0]     col_start_reg,  col_start_next;
    logic [11:0]     col_end_reg,    col_end_next;
    logic [11:0]     row_start_reg,  row_start_next;
    logic [11:0]     row_end_reg,    row_end_next;
    logic [12:0]     span_cols_reg,  span_cols_next;
    logic [12:0]     cols_left_reg,  cols_left_next;
    logic [12:0]     rows_left_reg,  rows_left_next;
    lwfs_pkg::comp_t comp_reg,       comp_next;
    logic [7:0]      fill_red_reg,   fill_red_next;
    logic [7:0]      fill_green_reg, fill_green_next;
    logic [7:0]      fill_blue_reg,  fill_blue_next;

    logic        rsp_valid_reg,    rsp_valid_next;
    logic [7:0]  tx_byte_reg,      tx_byte_next;
    logic        is_data_reg,      is_data_next;
    logic        transfer_end_reg, transfer_end_next;
    logic        fill_done_reg,    fill_done_next;

    logic            fire;
    logic            emit;
    lwfs_pkg::clip_t clip;

    assign fire      = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !fire;

    assign cfg_value = (cfg_data > lwfs_pkg::SCREEN_MAX) ? lwfs_pkg::SCREEN_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= lwfs_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= lwfs_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == lwfs_pkg::CFG_SCREEN_WIDTH)
            begin
                screen_width_reg <= cfg_value;
            end
            else
            begin
                screen_height_reg <= cfg_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            cmd_reg         <= cmd;
            rect_x_reg      <= rect_x;
            rect_y_reg      <= rect_y;
            rect_width_reg  <= rect_width;
            rect_height_reg <= rect_height;
            color_red_reg   <= color_red;
            color_green_reg <= color_green;
            color_blue_reg  <= color_blue;
        end
    end

    lwfs_clip u_clip
    (
        .rect_x        (rect_x_reg),
        .rect_y        (rect_y_reg),
        .rect_width    (rect_width_reg),
        .rect_height   (rect_height_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .clip          (clip)
    );

    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        row_start_next  = row_start_reg;
        row_end_next    = row_end_reg;
        span_cols_next  = span_cols_reg;
        cols_left_next  = cols_left_reg;
        rows_left_next  = rows_left_reg;
        comp_next       = comp_reg;
        fill_red_next   = fill_red_reg;
        fill_green_next = fill_green_reg;
        fill_blue_next  = fill_blue_reg;
        emit              = 1'b0;
        tx_byte_next      = tx_byte_reg;
        is_data_next      = is_data_reg;
        transfer_end_next = transfer_end_reg;
        fill_done_next    = fill_done_reg;

        if (fire && (cmd_reg == lwfs_pkg::REQ_START))
        begin
            if (!busy_reg && clip.accept)
            begin
                busy_next       = 1'b1;
                step_next       = lwfs_pkg::STEP_COL_CMD;
                col_start_next  = rect_x_reg;
                col_end_next    = clip.col_end;
                row_start_next  = rect_y_reg;
                row_end_next    = clip.row_end;
                span_cols_next  = clip.span_cols;
                cols_left_next  = clip.span_cols;
                rows_left_next  = clip.span_rows;
                comp_next       = lwfs_pkg::COMP_RED;
                fill_red_next   = color_red_reg;
                fill_green_next = color_green_reg;
                fill_blue_next  = color_blue_reg;
            end
        end
        else if (fire && busy_reg)
        begin
            emit              = 1'b1;
            is_data_next      = 1'b1;
            transfer_end_next = 1'b0;
            fill_done_next    = 1'b0;
            if (step_reg != lwfs_pkg::STEP_PIXEL)
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    lwfs_pkg::STEP_COL_CMD:
                    begin
                        tx_byte_next      = lwfs_pkg::CMD_COLUMN_SET;
                        is_data_next      = 1'b0;
                        transfer_end_next = 1'b1;
                    end
                    lwfs_pkg::STEP_COL_BEG_HI: tx_byte_next = {4'd0, col_start_reg[11:8]};
                    lwfs_pkg::STEP_COL_BEG_LO: tx_byte_next = col_start_reg[7:0];
                    lwfs_pkg::STEP_COL_END_HI: tx_byte_next = {4'd0, col_end_reg[11:8]};
                    lwfs_pkg::STEP_COL_END_LO:
                    begin
                        tx_byte_next      = col_end_reg[7:0];
                        transfer_end_next = 1'b1;
                    end
                    lwfs_pkg::STEP_ROW_CMD:
                    begin
                        tx_byte_next      = lwfs_pkg::CMD_ROW_SET;
                        is_data_next      = 1'b0;
                        transfer_end_next = 1'b1;
                    end
                    lwfs_pkg::STEP_ROW_BEG_HI: tx_byte_next = {4'd0, row_start_reg[11:8]};
                    lwfs_pkg::STEP_ROW_BEG_LO: tx_byte_next = row_start_reg[7:0];
                    lwfs_pkg::STEP_ROW_END_HI: tx_byte_next = {4'd0, row_end_reg[11:8]};
                    lwfs_pkg::STEP_ROW_END_LO:
                    begin
                        tx_byte_next      = row_end_reg[7:0];
                        transfer_end_next = 1'b1;
                    end
                    lwfs_pkg::STEP_WRITE_CMD:
                    begin
                        tx_byte_next      = lwfs_pkg::CMD_MEM_WRITE;
                        is_data_next      = 1'b0;
                        transfer_end_next = 1'b1;
                    end
                    default: tx_byte_next = 8'd0;
                endcase
            end
            else
            begin
                case (comp_reg)
                    lwfs_pkg::COMP_RED:
                    begin
                        tx_byte_next = fill_red_reg;
                        comp_next    = lwfs_pkg::COMP_GREEN;
                    end
                    lwfs_pkg::COMP_GREEN:
                    begin
                        tx_byte_next = fill_green_reg;
                        comp_next    = lwfs_pkg::COMP_BLUE;
                    end
                    default:
                    begin
                        tx_byte_next = fill_blue_reg;
                        comp_next    = lwfs_pkg::COMP_RED;
                        if (cols_left_reg != 13'd1)
                        begin
                            cols_left_next = cols_left_reg - 13'd1;
                        end
                        else if (rows_left_reg != 13'd1)
                        begin
                            cols_left_next = span_cols_reg;
                            rows_left_next = rows_left_reg - 13'd1;
                        end
                        else
                        begin
                            transfer_end_next = 1'b1;
                            fill_done_next    = 1'b1;
                            busy_next         = 1'b0;
                            step_next         = lwfs_pkg::STEP_COL_CMD;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (fire)
        begin
            rsp_valid_next = emit;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= lwfs_pkg::STEP_COL_CMD;
            comp_reg      <= lwfs_pkg::COMP_RED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            comp_reg      <= comp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_start_reg    <= col_start_next;
        col_end_reg      <= col_end_next;
        row_start_reg    <= row_start_next;
        row_end_reg      <= row_end_next;
        span_cols_reg    <= span_cols_next;
        cols_left_reg    <= cols_left_next;
        rows_left_reg    <= rows_left_next;
        fill_red_reg     <= fill_red_next;
        fill_green_reg   <= fill_green_next;
        fill_blue_reg    <= fill_blue_next;
        tx_byte_reg      <= tx_byte_next;
        is_data_reg      <= is_data_next;
        transfer_end_reg <= transfer_end_next;
        fill_done_reg    <= fill_done_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign is_data      = is_data_reg;
    assign transfer_end = transfer_end_reg;
    assign fill_done    = fill_done_reg;

    // The last pixel byte releases the sequencer in the same cycle that it is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && fill_done_reg |-> !busy_reg && transfer_end_reg && is_data_reg)
        else $error("fill done shown while the sequencer is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= lwfs_pkg::STEP_PIXEL)
        else $error("header step out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (step_reg == lwfs_pkg::STEP_PIXEL)
        |-> (cols_left_reg != 13'd0) && (rows_left_reg != 13'd0)
            && (cols_left_reg <= span_cols_reg))
        else $error("pixel counters out of range during a fill");

endmodule
